// File: hdl/cau_pkg.sv
package cau_pkg;

	localparam int FRAC_BITS        = 12;
	localparam int CORDIC_STEPS_DEF = 14;
	localparam int ANG_BITS         = 30;
	localparam int DATA_W           = 16;
	localparam int PROD_W           = 2 * DATA_W;
	localparam int SUM_W            = PROD_W + 1;
	localparam int MUL_W            = PROD_W + 2;
	localparam int DIR_W            = (MUL_W - FRAC_BITS > DATA_W + 2) ?
	                                  (MUL_W - FRAC_BITS) : (DATA_W + 2);
	localparam int QUO_W            = DATA_W + 1;
	localparam int DEN_W            = PROD_W;
	localparam int DIV_D_W          = DEN_W + 1;
	localparam int DIV_R_W          = DIV_D_W + QUO_W;
	localparam int DIV_N_W          = PROD_W + FRAC_BITS + 2;
	localparam int DIV_C_W          = (DIV_N_W > DIV_R_W) ? DIV_N_W : DIV_R_W;
	localparam int SQ_W             = PROD_W;
	localparam int SQ_STEPS         = DATA_W;
	localparam int CX_W             = 33;
	localparam int CZ_W             = 34;
	localparam int PRESCALE_SH      = 14;
	localparam int SAT_W            = 40;

	localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// atan(2^-i) with 30 fraction bits
	localparam logic signed [CZ_W-1:0] ATAN_TAB [32] = '{
		34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6,
		34'h003FEAB76, 34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55,
		34'h0003FFFEA, 34'h0001FFFFD, 34'h0000FFFFF, 34'h00007FFFF,
		34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF, 34'h000007FFF,
		34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
		34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F,
		34'h00000003F, 34'h00000001F, 34'h00000000F, 34'h000000008,
		34'h000000004, 34'h000000002, 34'h000000001, 34'h000000000
	};

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_CONJ = 4'd4;
	localparam logic [3:0] OP_NEG  = 4'd5;
	localparam logic [3:0] OP_MAG  = 4'd6;
	localparam logic [3:0] OP_ARG  = 4'd7;
	localparam logic [3:0] OP_EQ   = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0]               opcode;
		logic signed [DATA_W-1:0] a_re;
		logic signed [DATA_W-1:0] a_im;
		logic signed [DATA_W-1:0] b_re;
		logic signed [DATA_W-1:0] b_im;
	} cau_operand_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
		logic                     is_equal;
		logic [1:0]               status;
	} cau_result_t;

	typedef struct packed {
		logic [3:0]               opcode;
		logic signed [DIR_W-1:0]  dir_re;
		logic signed [DIR_W-1:0]  dir_im;
		logic                     eq;
		logic                     den_zero;
		logic                     ovf_re;
		logic                     ovf_im;
		logic                     neg_re;
		logic                     neg_im;
		logic [DIV_D_W-1:0]       div_d;
		logic [DIV_R_W-1:0]       rem_re;
		logic [DIV_R_W-1:0]       rem_im;
		logic [QUO_W-1:0]         quo_re;
		logic [QUO_W-1:0]         quo_im;
		logic [SQ_W-1:0]          sq_rem;
		logic [SQ_W-1:0]          sq_root;
		logic                     ph_skip;
		logic signed [CX_W-1:0]   cx;
		logic signed [CX_W-1:0]   cy;
		logic signed [CZ_W-1:0]   cz;
	} cau_iter_t;

	typedef struct packed {
		logic                     flag;
		logic signed [DATA_W-1:0] value;
	} cau_sat_t;

	function automatic cau_sat_t sat16(input logic signed [SAT_W-1:0] v);
		cau_sat_t r;
		if (v > 40'sd32767) begin
			r.flag  = 1'b1;
			r.value = 16'sh7FFF;
		end else if (v < -40'sd32768) begin
			r.flag  = 1'b1;
			r.value = 16'sh8000;
		end else begin
			r.flag  = 1'b0;
			r.value = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/cau_stage.sv
module cau_stage
	import cau_pkg::*;
#(
	parameter int STAGE        = 0,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  cau_iter_t src,
	output logic      dst_valid,
	output cau_iter_t dst
);

	logic [DIV_R_W-1:0]     rem_re_n, rem_im_n;
	logic [QUO_W-1:0]       quo_re_n, quo_im_n;
	logic [SQ_W-1:0]        sq_rem_n, sq_root_n;
	logic signed [CX_W-1:0] cx_n, cy_n;
	logic signed [CZ_W-1:0] cz_n;
	cau_iter_t              nxt;

	// One quotient bit per stage, most significant first.
	if (STAGE < QUO_W) begin : g_div
		localparam int B = QUO_W - 1 - STAGE;
		logic [DIV_R_W-1:0] trial;
		always_comb begin
			trial    = DIV_R_W'(src.div_d) << B;
			rem_re_n = src.rem_re;
			quo_re_n = src.quo_re;
			rem_im_n = src.rem_im;
			quo_im_n = src.quo_im;
			if (src.rem_re >= trial) begin
				rem_re_n    = src.rem_re - trial;
				quo_re_n[B] = 1'b1;
			end
			if (src.rem_im >= trial) begin
				rem_im_n    = src.rem_im - trial;
				quo_im_n[B] = 1'b1;
			end
		end
	end else begin : g_div_idle
		assign rem_re_n = src.rem_re;
		assign quo_re_n = src.quo_re;
		assign rem_im_n = src.rem_im;
		assign quo_im_n = src.quo_im;
	end

	// One result bit of the square root per stage.
	if (STAGE < SQ_STEPS) begin : g_sqrt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * STAGE);
		logic [SQ_W-1:0] sum;
		always_comb begin
			sum = src.sq_root + BITV;
			if (src.sq_rem >= sum) begin
				sq_rem_n  = src.sq_rem - sum;
				sq_root_n = (src.sq_root >> 1) + BITV;
			end else begin
				sq_rem_n  = src.sq_rem;
				sq_root_n = src.sq_root >> 1;
			end
		end
	end else begin : g_sqrt_idle
		assign sq_rem_n  = src.sq_rem;
		assign sq_root_n = src.sq_root;
	end

	// One vectoring rotation per stage.
	if (STAGE < CORDIC_STEPS) begin : g_cordic
		always_comb begin
			cx_n = $signed(src.cx);
			cy_n = $signed(src.cy);
			cz_n = $signed(src.cz);
			if (!src.ph_skip) begin
				if ($signed(src.cy) > 0) begin
					cx_n = $signed(src.cx) + ($signed(src.cy) >>> STAGE);
					cy_n = $signed(src.cy) - ($signed(src.cx) >>> STAGE);
					cz_n = $signed(src.cz) + ATAN_TAB[STAGE];
				end else begin
					cx_n = $signed(src.cx) - ($signed(src.cy) >>> STAGE);
					cy_n = $signed(src.cy) + ($signed(src.cx) >>> STAGE);
					cz_n = $signed(src.cz) - ATAN_TAB[STAGE];
				end
			end
		end
	end else begin : g_cordic_idle
		assign cx_n = src.cx;
		assign cy_n = src.cy;
		assign cz_n = src.cz;
	end

	always_comb begin
		nxt         = src;
		nxt.rem_re  = rem_re_n;
		nxt.rem_im  = rem_im_n;
		nxt.quo_re  = quo_re_n;
		nxt.quo_im  = quo_im_n;
		nxt.sq_rem  = sq_rem_n;
		nxt.sq_root = sq_root_n;
		nxt.cx      = cx_n;
		nxt.cy      = cy_n;
		nxt.cz      = cz_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else begin
			dst_valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		dst <= nxt;
	end

endmodule

// File: hdl/complex_arith_unit.sv
// Channel   Dir  Handshake                              Payload
// operands  in   start, taken when busy is low          cau_operand_t
// result    out  done, high for one cycle per result    cau_result_t
//
// A transaction can be taken on every clock; busy is held low.
// The pipeline depth is set by the quotient stages of the divider (one bit per stage)
// or by the CORDIC rotation stages when there are more of them.
// Reset clears the valid bits of every stage; data registers are not reset.
// Nothing stalls: the receiver takes each result in the cycle that it is shown.
module complex_arith_unit
	import cau_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  cau_operand_t operands,
	output logic         done,
	output cau_result_t  result
);

	localparam int ITER_STAGES = (CORDIC_STEPS > QUO_W) ? CORDIC_STEPS : QUO_W;
	localparam logic signed [MUL_W-1:0] HALF = MUL_W'(1) <<< (FRAC_BITS - 1);
	localparam int ANG_SH = ANG_BITS - FRAC_BITS;
	localparam logic signed [CZ_W-1:0] ANG_HALF = CZ_W'(1) <<< (ANG_SH - 1);

	logic signed [DATA_W-1:0] ar, ai, br, bi;

	assign busy = 1'b0;
	assign ar   = operands.a_re;
	assign ai   = operands.a_im;
	assign br   = operands.b_re;
	assign bi   = operands.b_im;

	// Stage 1: all partial products.
	logic                     v_s1;
	logic [3:0]               op_s1;
	logic signed [DATA_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PROD_W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PROD_W-1:0] p_ar2_s1, p_ai2_s1, p_br2_s1, p_bi2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= operands.opcode;
		ar_s1    <= ar;
		ai_s1    <= ai;
		br_s1    <= br;
		bi_s1    <= bi;
		p_rr_s1  <= PROD_W'(ar) * PROD_W'(br);
		p_ii_s1  <= PROD_W'(ai) * PROD_W'(bi);
		p_ri_s1  <= PROD_W'(ar) * PROD_W'(bi);
		p_ir_s1  <= PROD_W'(ai) * PROD_W'(br);
		p_ar2_s1 <= PROD_W'(ar) * PROD_W'(ar);
		p_ai2_s1 <= PROD_W'(ai) * PROD_W'(ai);
		p_br2_s1 <= PROD_W'(br) * PROD_W'(br);
		p_bi2_s1 <= PROD_W'(bi) * PROD_W'(bi);
	end

	// Stage 2: sums, direct results and the division numerators.
	logic                     v_s2;
	logic [3:0]               op_s2;
	logic signed [DATA_W-1:0] ar_s2, ai_s2;
	logic signed [DIR_W-1:0]  dir_re_s2, dir_im_s2;
	logic                     eq_s2;
	logic signed [SUM_W-1:0]  num_re_s2, num_im_s2;
	logic [DEN_W-1:0]         den_s2;
	logic [SQ_W-1:0]          mag_s2;
	logic signed [DIR_W-1:0]  dir_re_n, dir_im_n;
	logic signed [MUL_W-1:0]  mul_re_w, mul_im_w;

	always_comb begin
		mul_re_w = MUL_W'(p_rr_s1) - MUL_W'(p_ii_s1) + HALF;
		mul_im_w = MUL_W'(p_ri_s1) + MUL_W'(p_ir_s1) + HALF;
		case (op_s1)
			OP_ADD: begin
				dir_re_n = DIR_W'(ar_s1) + DIR_W'(br_s1);
				dir_im_n = DIR_W'(ai_s1) + DIR_W'(bi_s1);
			end
			OP_SUB: begin
				dir_re_n = DIR_W'(ar_s1) - DIR_W'(br_s1);
				dir_im_n = DIR_W'(ai_s1) - DIR_W'(bi_s1);
			end
			OP_MUL: begin
				dir_re_n = DIR_W'(mul_re_w >>> FRAC_BITS);
				dir_im_n = DIR_W'(mul_im_w >>> FRAC_BITS);
			end
			OP_CONJ: begin
				dir_re_n = DIR_W'(ar_s1);
				dir_im_n = -DIR_W'(ai_s1);
			end
			OP_NEG: begin
				dir_re_n = -DIR_W'(ar_s1);
				dir_im_n = -DIR_W'(ai_s1);
			end
			default: begin
				dir_re_n = '0;
				dir_im_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		ar_s2     <= ar_s1;
		ai_s2     <= ai_s1;
		dir_re_s2 <= dir_re_n;
		dir_im_s2 <= dir_im_n;
		eq_s2     <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		num_re_s2 <= SUM_W'(p_rr_s1) + SUM_W'(p_ii_s1);
		num_im_s2 <= SUM_W'(p_ir_s1) - SUM_W'(p_ri_s1);
		den_s2    <= DEN_W'(p_br2_s1) + DEN_W'(p_bi2_s1);
		mag_s2    <= SQ_W'(p_ar2_s1) + SQ_W'(p_ai2_s1);
	end

	// Stage 3: set up the divider, square root and CORDIC.
	logic                   v_s3;
	cau_iter_t              it_s3;
	cau_iter_t              it_n;
	logic [PROD_W-1:0]      abs_re, abs_im;
	logic [DIV_N_W-1:0]     n_re, n_im;
	logic [DIV_C_W-1:0]     lim;
	logic signed [CX_W-1:0] x0, y0;

	always_comb begin
		abs_re = (num_re_s2 < 0) ? PROD_W'(-num_re_s2) : PROD_W'(num_re_s2);
		abs_im = (num_im_s2 < 0) ? PROD_W'(-num_im_s2) : PROD_W'(num_im_s2);
		// Rounding to nearest: floor((2n + d) / 2d) with n the scaled numerator.
		n_re   = (DIV_N_W'(abs_re) << (FRAC_BITS + 1)) + DIV_N_W'(den_s2);
		n_im   = (DIV_N_W'(abs_im) << (FRAC_BITS + 1)) + DIV_N_W'(den_s2);
		x0     = CX_W'(ar_s2) <<< PRESCALE_SH;
		y0     = CX_W'(ai_s2) <<< PRESCALE_SH;

		it_n          = '0;
		it_n.opcode   = op_s2;
		it_n.dir_re   = dir_re_s2;
		it_n.dir_im   = dir_im_s2;
		it_n.eq       = eq_s2;
		it_n.den_zero = (den_s2 == '0);
		it_n.neg_re   = (num_re_s2 < 0);
		it_n.neg_im   = (num_im_s2 < 0);
		it_n.div_d    = DIV_D_W'(den_s2) << 1;
		lim           = DIV_C_W'(it_n.div_d) << QUO_W;
		it_n.ovf_re   = (DIV_C_W'(n_re) >= lim);
		it_n.ovf_im   = (DIV_C_W'(n_im) >= lim);
		it_n.rem_re   = DIV_R_W'(n_re);
		it_n.rem_im   = DIV_R_W'(n_im);
		it_n.sq_rem   = mag_s2;

		if (ar_s2 == 0) begin
			it_n.ph_skip = 1'b1;
			if (ai_s2 == 0) begin
				it_n.cz = '0;
			end else if (ai_s2 > 0) begin
				it_n.cz = HALF_PI_Q30;
			end else begin
				it_n.cz = -HALF_PI_Q30;
			end
		end else if (ar_s2 < 0) begin
			// Rotate into the right half plane first.
			it_n.cx = -x0;
			it_n.cy = -y0;
			it_n.cz = (ai_s2 >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			it_n.cx = x0;
			it_n.cy = y0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s3 <= it_n;
	end

	// Iteration stages.
	logic [ITER_STAGES:0] iv;
	cau_iter_t            ist [ITER_STAGES+1];

	assign iv[0]  = v_s3;
	assign ist[0] = it_s3;

	for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
		cau_stage #(
			.STAGE        (k),
			.CORDIC_STEPS (CORDIC_STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (iv[k]),
			.src       (ist[k]),
			.dst_valid (iv[k+1]),
			.dst       (ist[k+1])
		);
	end

	// Final stage: rounding, saturation and selection.
	cau_iter_t               fin;
	cau_result_t             res_n;
	cau_sat_t                s_re, s_im;
	logic signed [SAT_W-1:0] q_re, q_im;
	logic [SQ_W-1:0]         root_r;
	logic signed [CZ_W-1:0]  ang;
	logic                    done_q;
	cau_result_t             result_q;

	assign fin = ist[ITER_STAGES];

	always_comb begin
		q_re   = fin.ovf_re ? 40'sd65536 : SAT_W'(fin.quo_re);
		q_im   = fin.ovf_im ? 40'sd65536 : SAT_W'(fin.quo_im);
		q_re   = fin.neg_re ? -q_re : q_re;
		q_im   = fin.neg_im ? -q_im : q_im;
		root_r = fin.sq_root + SQ_W'(fin.sq_rem > fin.sq_root);
		ang    = ($signed(fin.cz) + ANG_HALF) >>> ANG_SH;
		s_re   = '0;
		s_im   = '0;
		res_n  = '0;
		case (fin.opcode)
			OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_NEG: begin
				s_re = sat16(SAT_W'($signed(fin.dir_re)));
				s_im = sat16(SAT_W'($signed(fin.dir_im)));
			end
			OP_DIV: begin
				if (!fin.den_zero) begin
					s_re = sat16(q_re);
					s_im = sat16(q_im);
				end
			end
			OP_MAG: begin
				s_re = sat16(SAT_W'(root_r));
			end
			OP_ARG: begin
				s_re = sat16(SAT_W'(ang));
			end
			OP_EQ: begin
				res_n.is_equal = fin.eq;
			end
			default: begin
				res_n.is_equal = 1'b0;
			end
		endcase
		res_n.res_re = s_re.value;
		res_n.res_im = s_im.value;
		if ((fin.opcode == OP_DIV) && fin.den_zero) begin
			res_n.status = ST_DIV0;
		end else if (s_re.flag || s_im.flag) begin
			res_n.status = ST_SAT;
		end else begin
			res_n.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= iv[ITER_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_n;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hdl/cau_checker.sv
module cau_checker
	import cau_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input cau_result_t result
);

	localparam int LAT = ((CORDIC_STEPS > QUO_W) ? CORDIC_STEPS : QUO_W) + 4;

	// Every accepted transaction comes back after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction gave no result at the expected cycle");

	// No result appears without a transaction that caused it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without an accepted transaction");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although the pipeline never stalls");

	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_equal) |->
		(result.res_re == 0 && result.res_im == 0 && result.status == ST_OK))
		else $error("equality result carries a value or a status");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DIV0) |->
		(result.res_re == 0 && result.res_im == 0 && !result.is_equal))
		else $error("divide by zero result is not zero");

endmodule

bind complex_arith_unit cau_checker #(
	.CORDIC_STEPS (CORDIC_STEPS)
) u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: tb/tb_top.sv
module tb_top;
	import cau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY        = 21;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1650;

	class cau_scoreboard;
		cau_result_t expected_results[$];
		int          errors;
		int          checked;
		int          op_seen[16];

		function automatic longint clip16(longint v, ref logic [1:0] st);
			if (v > 32767) begin
				st = ST_SAT;
				return 32767;
			end
			if (v < -32768) begin
				st = ST_SAT;
				return -32768;
			end
			return v;
		endfunction

		// Rounds half away from zero; den is never zero here.
		function automatic longint div_nearest(longint num, longint den);
			longint n, q;
			n = (num < 0 ? -num : num) <<< FRAC_BITS;
			q = (2 * n + den) / (2 * den);
			return num < 0 ? -q : q;
		endfunction

		function automatic longint root_nearest(longint n);
			longint r, b;
			r = 0;
			b = longint'(1) <<< 62;
			while (b > n)
				b = b >>> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			if (n > r)
				r++;
			return r;
		endfunction

		// Vectoring CORDIC; the angle is kept with 30 fraction bits.
		function automatic longint angle_q30(longint x0, longint y0);
			longint x, y, z, nx, ny;
			z = 0;
			if (x0 == 0) begin
				if (y0 == 0)
					return 0;
				return y0 > 0 ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
			end
			x = x0 <<< PRESCALE_SH;
			y = y0 <<< PRESCALE_SH;
			if (x0 < 0) begin
				x = -x;
				y = -y;
				z = (y0 >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
			end
			for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z  = z + longint'(ATAN_TAB[i]);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z  = z - longint'(ATAN_TAB[i]);
				end
				x = nx;
				y = ny;
			end
			return z;
		endfunction

		function automatic cau_result_t predict_result(cau_operand_t x);
			cau_result_t r;
			longint ar, ai, br, bi, re, im, den, half;
			logic [1:0] st;
			ar   = longint'(x.a_re);
			ai   = longint'(x.a_im);
			br   = longint'(x.b_re);
			bi   = longint'(x.b_im);
			re   = 0;
			im   = 0;
			half = longint'(1) <<< (FRAC_BITS - 1);
			st   = ST_OK;
			r    = '0;
			case (x.opcode)
				OP_ADD: begin
					re = ar + br;
					im = ai + bi;
				end
				OP_SUB: begin
					re = ar - br;
					im = ai - bi;
				end
				OP_MUL: begin
					re = (ar * br - ai * bi + half) >>> FRAC_BITS;
					im = (ar * bi + ai * br + half) >>> FRAC_BITS;
				end
				OP_DIV: begin
					den = br * br + bi * bi;
					if (den == 0) begin
						st = ST_DIV0;
					end else begin
						re = div_nearest(ar * br + ai * bi, den);
						im = div_nearest(br * ai - ar * bi, den);
					end
				end
				OP_CONJ: begin
					re = ar;
					im = -ai;
				end
				OP_NEG: begin
					re = -ar;
					im = -ai;
				end
				OP_MAG: re = root_nearest(ar * ar + ai * ai);
				OP_ARG: re = (angle_q30(ar, ai) + (longint'(1) <<< (ANG_BITS - FRAC_BITS - 1)))
				             >>> (ANG_BITS - FRAC_BITS);
				OP_EQ: r.is_equal = (ar == br) && (ai == bi);
				default: ;
			endcase
			re       = clip16(re, st);
			im       = clip16(im, st);
			r.res_re = re[DATA_W-1:0];
			r.res_im = im[DATA_W-1:0];
			r.status = st;
			return r;
		endfunction

		function void note_operands(cau_operand_t x);
			op_seen[x.opcode]++;
			expected_results.push_back(predict_result(x));
		endfunction

		function void check_result(cau_result_t got);
			cau_result_t exp;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $realtime, got);
				return;
			end
			exp = expected_results.pop_front();
			checked++;
			if (got.res_re !== exp.res_re || got.res_im !== exp.res_im ||
			    got.is_equal !== exp.is_equal || got.status !== exp.status) begin
				errors++;
				$display("%0t: mismatch re/im/eq/st expected %0d/%0d/%b/%0d actual %0d/%0d/%b/%0d",
				         $realtime, exp.res_re, exp.res_im, exp.is_equal, exp.status,
				         got.res_re, got.res_im, got.is_equal, got.status);
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic         done;
	cau_operand_t operands;
	cau_result_t  result;

	cau_scoreboard sb = new();
	int            quiet_cycles;
	int            idle_pct;

	complex_arith_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (start && !busy)
				sb.note_operands(operands);
			if (done)
				sb.check_result(result);
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $realtime);
				$display("FAIL complex_arith_unit");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_operands(cau_operand_t x);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		operands <= x;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send(logic [3:0] op, int ar, int ai, int br, int bi);
		cau_operand_t x;
		x.opcode = op;
		x.a_re   = ar[15:0];
		x.a_im   = ai[15:0];
		x.b_re   = br[15:0];
		x.b_im   = bi[15:0];
		send_operands(x);
	endtask

	function automatic logic [15:0] random_part();
		case ($urandom_range(4))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(8192) - 4096);
			3: case ($urandom_range(4))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'hFFFF;
				3: return 16'h0001;
				default: return 16'h0000;
			endcase
			default: return 16'($urandom_range(512) - 256);
		endcase
	endfunction

	task automatic send_random();
		cau_operand_t x;
		x.opcode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) :
		           4'($urandom_range(8));
		x.a_re = random_part();
		x.a_im = random_part();
		x.b_re = random_part();
		x.b_im = random_part();
		// Equality is only interesting when it sometimes holds.
		if (x.opcode == OP_EQ && $urandom_range(1)) begin
			x.b_re = x.a_re;
			x.b_im = ($urandom_range(3) == 0) ? x.a_im ^ 16'(1 << $urandom_range(15)) : x.a_im;
		end
		if (x.opcode == OP_DIV && $urandom_range(15) == 0) begin
			x.b_re = '0;
			x.b_im = '0;
		end
		send_operands(x);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		operands     = '0;
		quiet_cycles = 0;
		idle_pct     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_ADD, 32767, 32767, 32767, 32767);
		send(OP_ADD, -32768, 100, -1, -200);
		send(OP_SUB, -32768, 32767, 32767, -32768);
		send(OP_SUB, 1234, -5678, 1234, -5678);
		send(OP_MUL, -32768, 0, -32768, 0);
		send(OP_MUL, -32768, -32768, -32768, -32768);
		send(OP_MUL, 4096, 2048, -4096, 1);
		send(OP_DIV, 4096, 4096, 0, 0);
		send(OP_DIV, 8192, -4096, 4096, 4096);
		send(OP_DIV, 32767, 32767, 1, 0);
		send(OP_DIV, -3, 7, -32768, 32767);
		send(OP_CONJ, -32768, -32768, 0, 0);
		send(OP_NEG, -32768, 32767, 0, 0);
		send(OP_MAG, -32768, -32768, 0, 0);
		send(OP_MAG, 0, 0, 0, 0);
		send(OP_MAG, 3, 4, 0, 0);
		send(OP_ARG, 0, 0, 0, 0);
		send(OP_ARG, 0, 5, 0, 0);
		send(OP_ARG, 0, -32768, 0, 0);
		send(OP_ARG, -1, 0, 0, 0);
		send(OP_ARG, 32767, 0, 0, 0);
		send(OP_ARG, -4096, -1, 0, 0);
		send(OP_EQ, -32768, 32767, -32768, 32767);
		send(OP_EQ, 1, 2, 1, 3);
		send(4'd9, 100, 100, 100, 100);
		send(4'd15, -1, -1, -1, -1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				idle_pct = 47;
			else if (i == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			else if (i == 0)
				idle_pct = 7;
			send_random();
		end
		start <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.errors++;

		$display("Checked %0d results; opcodes seen add %0d sub %0d mul %0d div %0d",
		         sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
		$display("conj %0d neg %0d mag %0d arg %0d eq %0d, errors %0d", sb.op_seen[4],
		         sb.op_seen[5], sb.op_seen[6], sb.op_seen[7], sb.op_seen[8], sb.errors);
		if (sb.errors == 0)
			$display("PASS complex_arith_unit");
		else
			$display("FAIL complex_arith_unit");
		$finish;
	end

endmodule
